// File: hw/rtl/three_point_bezier_interpolator_macros.svh
// Assertion macros used by the interpolator checker.
`ifndef THREE_POINT_BEZIER_INTERPOLATOR_MACROS_SVH
`define THREE_POINT_BEZIER_INTERPOLATOR_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define BZI_ASSERT_PROP(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");

// Implication built on the macro above.
`define BZI_ASSERT_IMPLY(name, clk, rst_n, cond, conseq) \
	`BZI_ASSERT_PROP(name, clk, rst_n, (cond) |-> conseq)

`endif

// File: hw/rtl/bzi_pkg.sv
// Shared constants for the three point Bezier interpolator.
`default_nettype none

package bzi_pkg;

	localparam int DEF_SAMPLE_BITS   = 16;
	localparam int DEF_POS_FRAC_BITS = 16;

	// cycles from an accepted word to its result strobe
	localparam int LATENCY = 8;

endpackage

`default_nettype wire

// File: hw/rtl/three_point_bezier_interpolator.sv
// Top level of the three point slope limited Bezier interpolator.
`default_nettype none

// Takes one word per clock: a word is taken at every rising edge with start
// high, and busy never rises. Each result appears on interpolated_value with
// done high for exactly one cycle, in the order the words came in; there is
// no way to hold results back, so the receiver must capture every strobe.
// The pipeline is three front stages (position folding, slope limiting,
// control points) and five evaluation stages built around two multiplier
// levels, the rounding add and the clamp.

module three_point_bezier_interpolator #(
	parameter int SAMPLE_BITS            = bzi_pkg::DEF_SAMPLE_BITS,
	parameter int POSITION_FRACTION_BITS = bzi_pkg::DEF_POS_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [SAMPLE_BITS-1:0]          first_sample,
	input  logic signed [SAMPLE_BITS-1:0]          middle_sample,
	input  logic signed [SAMPLE_BITS-1:0]          last_sample,
	input  logic        [POSITION_FRACTION_BITS:0] position,
	output logic                                   done,
	output logic signed [SAMPLE_BITS-1:0]          interpolated_value
);

	logic                          cp_valid;
	logic signed [SAMPLE_BITS+2:0] cp0, cp1, cp2;
	logic [POSITION_FRACTION_BITS:0] wa, wb;

	// fully pipelined: never refuse a word
	assign busy = 1'b0;

	bzi_ctrl #(
		.SAMPLE_BITS            (SAMPLE_BITS),
		.POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start && !busy),
		.first_sample  (first_sample),
		.middle_sample (middle_sample),
		.last_sample   (last_sample),
		.position      (position),
		.out_valid     (cp_valid),
		.p0            (cp0),
		.p1            (cp1),
		.p2            (cp2),
		.a             (wa),
		.b             (wb)
	);

	bzi_eval #(
		.SAMPLE_BITS            (SAMPLE_BITS),
		.POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
	) u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cp_valid),
		.p0        (cp0),
		.p1        (cp1),
		.p2        (cp2),
		.a         (wa),
		.b         (wb),
		.out_valid (done),
		.value     (interpolated_value)
	);

endmodule

`default_nettype wire

// File: hw/rtl/bzi_ctrl.sv
// Front pipeline: position folding, slope limiting and control point selection.
`default_nettype none

module bzi_ctrl #(
	parameter int SAMPLE_BITS            = bzi_pkg::DEF_SAMPLE_BITS,
	parameter int POSITION_FRACTION_BITS = bzi_pkg::DEF_POS_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [SAMPLE_BITS-1:0]       first_sample,
	input  logic signed [SAMPLE_BITS-1:0]       middle_sample,
	input  logic signed [SAMPLE_BITS-1:0]       last_sample,
	input  logic        [POSITION_FRACTION_BITS:0] position,
	output logic                                out_valid,
	output logic signed [SAMPLE_BITS+2:0]       p0,
	output logic signed [SAMPLE_BITS+2:0]       p1,
	output logic signed [SAMPLE_BITS+2:0]       p2,
	output logic        [POSITION_FRACTION_BITS:0] a,
	output logic        [POSITION_FRACTION_BITS:0] b
);

	localparam int SB = SAMPLE_BITS;
	localparam int F  = POSITION_FRACTION_BITS;
	localparam int PW = SB + 3;
	localparam int AB = SB + 3;

	localparam logic [F:0]   ONE_POS   = {1'b1, {F{1'b0}}};
	localparam logic [F:0]   HALF_POS  = {2'b01, {(F-1){1'b0}}};
	localparam logic [F+1:0] ONE_POS_W = {2'b01, {F{1'b0}}};

	// stage 1: fold position, take differences
	logic [F:0]   u_sat;
	logic [F+1:0] u_twice;
	logic [F+1:0] t_right;
	logic [F:0]   t_c;
	logic         left_c;
	logic         flat_c;

	assign u_sat   = (position > ONE_POS) ? ONE_POS : position;
	assign left_c  = (u_sat <= HALF_POS);
	assign flat_c  = (left_c && (first_sample == middle_sample)) ||
		((u_sat >= HALF_POS) && (middle_sample == last_sample));
	assign u_twice = {u_sat, 1'b0};
	assign t_right = u_twice - ONE_POS_W;
	assign t_c     = left_c ? u_twice[F:0] : t_right[F:0];

	logic                 v_s1;
	logic signed [SB-1:0] y1_s1, y2_s1, y3_s1;
	logic signed [SB:0]   d21_s1, d32_s1, d31_s1;
	logic [F:0]           t_s1;
	logic                 left_s1, flat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		y1_s1   <= first_sample;
		y2_s1   <= middle_sample;
		y3_s1   <= last_sample;
		d21_s1  <= (SB+1)'(middle_sample) - (SB+1)'(first_sample);
		d32_s1  <= (SB+1)'(last_sample) - (SB+1)'(middle_sample);
		d31_s1  <= (SB+1)'(last_sample) - (SB+1)'(first_sample);
		t_s1    <= t_c;
		left_s1 <= left_c;
		flat_s1 <= flat_c;
	end

	// stage 2: limit the end-to-end slope
	logic signed [SB+1:0] s12, s23, slope_c;
	logic signed [AB-1:0] e31, e12, e23;
	logic        [AB-1:0] abs31, abs12, abs23;
	logic                 extreme_c;

	assign s12   = $signed({d21_s1, 1'b0});
	assign s23   = $signed({d32_s1, 1'b0});
	assign e31   = AB'(d31_s1);
	assign e12   = AB'(s12);
	assign e23   = AB'(s23);
	assign abs31 = e31[AB-1] ? -e31 : e31;
	assign abs12 = e12[AB-1] ? -e12 : e12;
	assign abs23 = e23[AB-1] ? -e23 : e23;

	// peak or valley: middle sample does not lie strictly between its neighbours
	assign extreme_c = (!d21_s1[SB] && (d32_s1[SB] || (d32_s1 == '0))) ||
		((d21_s1[SB] || (d21_s1 == '0)) && !d32_s1[SB]);

	always_comb begin
		priority if (extreme_c) begin
			slope_c = '0;
		end else if (abs31 > abs12) begin
			slope_c = s12;
		end else if (abs31 > abs23) begin
			slope_c = s23;
		end else begin
			slope_c = (SB+2)'(d31_s1);
		end
	end

	logic                 v_s2;
	logic signed [SB-1:0] y1_s2, y2_s2, y3_s2;
	logic signed [SB+1:0] slope_s2;
	logic [F:0]           t_s2;
	logic                 left_s2, flat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		y1_s2    <= y1_s1;
		y2_s2    <= y2_s1;
		y3_s2    <= y3_s1;
		slope_s2 <= slope_c;
		t_s2     <= t_s1;
		left_s2  <= left_s1;
		flat_s2  <= flat_s1;
	end

	// stage 3: control points in Q.1
	logic signed [PW-1:0] tw1, tw2, tw3, sl;
	logic signed [PW-1:0] p0_c, p1_c, p2_c;

	assign tw1 = PW'($signed({y1_s2, 1'b0}));
	assign tw2 = PW'($signed({y2_s2, 1'b0}));
	assign tw3 = PW'($signed({y3_s2, 1'b0}));
	assign sl  = PW'(slope_s2);

	always_comb begin
		if (flat_s2) begin
			// all points on the middle sample give it back exactly
			p0_c = tw2;
			p1_c = tw2;
			p2_c = tw2;
		end else if (left_s2) begin
			p0_c = tw1;
			p1_c = tw2 - sl;
			p2_c = tw2;
		end else begin
			p0_c = tw2;
			p1_c = tw2 + sl;
			p2_c = tw3;
		end
	end

	logic                 v_s3;
	logic signed [PW-1:0] p0_s3, p1_s3, p2_s3;
	logic [F:0]           a_s3, b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p0_s3 <= p0_c;
		p1_s3 <= p1_c;
		p2_s3 <= p2_c;
		a_s3  <= ONE_POS - t_s2;
		b_s3  <= t_s2;
	end

	assign out_valid = v_s3;
	assign p0        = p0_s3;
	assign p1        = p1_s3;
	assign p2        = p2_s3;
	assign a         = a_s3;
	assign b         = b_s3;

endmodule

`default_nettype wire

// File: hw/rtl/bzi_eval.sv
// Back pipeline: quadratic Bezier evaluation, rounding and clamping.
`default_nettype none

module bzi_eval #(
	parameter int SAMPLE_BITS            = bzi_pkg::DEF_SAMPLE_BITS,
	parameter int POSITION_FRACTION_BITS = bzi_pkg::DEF_POS_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [SAMPLE_BITS+2:0]       p0,
	input  logic signed [SAMPLE_BITS+2:0]       p1,
	input  logic signed [SAMPLE_BITS+2:0]       p2,
	input  logic        [POSITION_FRACTION_BITS:0] a,
	input  logic        [POSITION_FRACTION_BITS:0] b,
	output logic                                out_valid,
	output logic signed [SAMPLE_BITS-1:0]       value
);

	localparam int SB  = SAMPLE_BITS;
	localparam int F   = POSITION_FRACTION_BITS;
	localparam int QW  = SB + F + 6;
	localparam int DW  = QW + 1;
	localparam int PHW = DW + 2;
	localparam int LW  = 2 * F + 1;
	localparam int NW  = DW + F + 4;
	localparam int RW  = NW - LW;

	localparam logic signed [NW-1:0] RND =
		{{(NW-LW){1'b0}}, 1'b1, {(2*F){1'b0}}};
	localparam logic signed [RW-1:0] MAXV = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [RW-1:0] MINV = {{(RW-SB+1){1'b1}}, {(SB-1){1'b0}}};

	// stage 4: first de Casteljau level, q = a*p0 + b*p1, r = a*p1 + b*p2
	logic signed [QW-1:0] as, bs;
	logic signed [QW-1:0] q_c, r_c;

	assign as  = QW'($signed({1'b0, a}));
	assign bs  = QW'($signed({1'b0, b}));
	assign q_c = as * QW'(p0) + bs * QW'(p1);
	assign r_c = as * QW'(p1) + bs * QW'(p2);

	logic                 v_s4;
	logic signed [QW-1:0] q_s4, r_s4;
	logic [F:0]           b_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		q_s4 <= q_c;
		r_s4 <= r_c;
		b_s4 <= b;
	end

	// stage 5: difference between the two levels
	logic                 v_s5;
	logic signed [DW-1:0] d_s5;
	logic signed [QW-1:0] q_s5;
	logic [F:0]           b_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		d_s5 <= DW'(r_s4) - DW'(q_s4);
		q_s5 <= q_s4;
		b_s5 <= b_s4;
	end

	// stage 6: split the difference so each product stays narrow
	logic signed [DW-F-1:0] dh;
	logic        [F-1:0]    dl;

	assign dh = $signed(d_s5[DW-1:F]);
	assign dl = d_s5[F-1:0];

	logic                  v_s6;
	logic signed [PHW-1:0] ph_s6;
	logic        [LW-1:0]  pl_s6;
	logic signed [QW-1:0]  q_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		ph_s6 <= PHW'($signed({1'b0, b_s5})) * PHW'(dh);
		pl_s6 <= LW'(b_s5) * LW'(dl);
		q_s6  <= q_s5;
	end

	// stage 7: recombine, add half and drop the fraction
	logic signed [NW-1:0] sum_c;

	assign sum_c = (NW'(q_s6) <<< F) + (NW'(ph_s6) <<< F) +
		$signed(NW'(pl_s6)) + RND;

	logic                 v_s7;
	logic signed [RW-1:0] res_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		res_s7 <= $signed(sum_c[NW-1:LW]);
	end

	// stage 8: clamp to the sample range
	logic signed [RW-1:0] clamp_c;

	always_comb begin
		priority if (res_s7 > MAXV) begin
			clamp_c = MAXV;
		end else if (res_s7 < MINV) begin
			clamp_c = MINV;
		end else begin
			clamp_c = res_s7;
		end
	end

	logic                 v_s8;
	logic signed [SB-1:0] value_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		value_s8 <= clamp_c[SB-1:0];
	end

	assign out_valid = v_s8;
	assign value     = value_s8;

endmodule

`default_nettype wire

// File: hw/rtl/bzi_checker.sv
// Port level checks for the interpolator, bound to the top level.
`default_nettype none

`include "three_point_bezier_interpolator_macros.svh"

module bzi_checker #(
	parameter int SAMPLE_BITS            = bzi_pkg::DEF_SAMPLE_BITS,
	parameter int POSITION_FRACTION_BITS = bzi_pkg::DEF_POS_FRAC_BITS
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   start,
	input logic                                   busy,
	input logic signed [SAMPLE_BITS-1:0]          first_sample,
	input logic signed [SAMPLE_BITS-1:0]          middle_sample,
	input logic signed [SAMPLE_BITS-1:0]          last_sample,
	input logic        [POSITION_FRACTION_BITS:0] position,
	input logic                                   done,
	input logic signed [SAMPLE_BITS-1:0]          interpolated_value
);

	import bzi_pkg::*;

	localparam logic [POSITION_FRACTION_BITS:0] HALF_POS =
		{2'b01, {(POSITION_FRACTION_BITS-1){1'b0}}};

	// every taken word yields a strobe after the fixed latency
	`BZI_ASSERT_IMPLY(a_word_done, clk, arst_n, start && !busy, (##LATENCY done))

	// no strobe without a word taken that long ago
	`BZI_ASSERT_IMPLY(a_done_word, clk, arst_n, done, $past(start && !busy, LATENCY))

	// flat left half returns the middle sample
	`BZI_ASSERT_IMPLY(a_flat_left, clk, arst_n, start && !busy && (first_sample == middle_sample) && (position <= HALF_POS), (##LATENCY (interpolated_value == $past(middle_sample, LATENCY))))

	// flat right half returns the middle sample
	`BZI_ASSERT_IMPLY(a_flat_right, clk, arst_n, start && !busy && (last_sample == middle_sample) && (position >= HALF_POS), (##LATENCY (interpolated_value == $past(middle_sample, LATENCY))))

endmodule

bind three_point_bezier_interpolator bzi_checker #(
	.SAMPLE_BITS            (SAMPLE_BITS),
	.POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
) u_bzi_checker (.*);

`default_nettype wire
